/* src/fragt_pkg.sv */
// ----------------------------------------------------------------------------
// fragt_pkg
// Shared types and constants for the IPv4 fragment tracker: the fragment
// descriptor, the result record, the slot memory word and the controller
// state encoding.
// ----------------------------------------------------------------------------
package fragt_pkg;

    localparam int ID_W    = 16;
    localparam int OFF_W   = 16;
    localparam int PLEN_W  = 16;
    localparam int TIME_W  = 32;
    localparam int LEN_W   = 17;
    localparam int KIND_W  = 3;
    localparam int PCNT_W  = 5;
    localparam int AGE_W   = 16;

    localparam logic [AGE_W-1:0]  PURGE_AGE_RESET = 16'd5000;
    localparam logic [LEN_W-1:0]  LEN_MAX         = 17'h1FFFF;
    localparam logic [PCNT_W-1:0] PCNT_MAX        = 5'd31;

    localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PASS     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STORED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd4;

    typedef struct packed {
        logic              is_ipv4;
        logic [ID_W-1:0]   ip_id;
        logic [OFF_W-1:0]  frag_offset;
        logic              more_fragments;
        logic [PLEN_W-1:0] payload_length;
        logic [TIME_W-1:0] now_ms;
    } frag_desc_t;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [ID_W-1:0]   packet_id;
        logic [LEN_W-1:0]  assembled_length;
        logic [PCNT_W-1:0] purged_count;
    } frag_result_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  received;
        logic [LEN_W-1:0]  total;
        logic [TIME_W-1:0] stamp;
    } slot_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } ctrl_state_t;

endpackage

/* src/ipv4_fragment_tracker.sv */
// ----------------------------------------------------------------------------
// ipv4_fragment_tracker
// Bookkeeping for IPv4 fragment reassembly: tracks received and total length
// per identification in a slot table, reports completion and ages out idle
// slots.
//
// Channel  Direction  Handshake           Contents
// s_*      in         s_valid / s_ready   fragment descriptor
// m_*      out        m_valid / m_ready   result kind, id, length, purge count
// cfg_*    in         cfg_wr_en           purge age in milliseconds
//
// A non-IPv4 transaction goes from idle straight to the finish step. An
// IPv4 transaction scans every slot through the single read port of the
// slot memory, then passes through the drain and finish steps.
// Reset is synchronous and active low; it clears all slots and restores the
// purge age to 5000 ms. The output register lets the next transaction be
// scanned while a result waits; a stalled output holds the controller in its
// finish step.
// ----------------------------------------------------------------------------
module ipv4_fragment_tracker #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_is_ipv4,
    input  logic [fragt_pkg::ID_W-1:0]        s_ip_id,
    input  logic [fragt_pkg::OFF_W-1:0]       s_frag_offset,
    input  logic                              s_more_fragments,
    input  logic [fragt_pkg::PLEN_W-1:0]      s_payload_length,
    input  logic [fragt_pkg::TIME_W-1:0]      s_now_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fragt_pkg::KIND_W-1:0]      m_result_kind,
    output logic [fragt_pkg::ID_W-1:0]        m_packet_id,
    output logic [fragt_pkg::LEN_W-1:0]       m_assembled_length,
    output logic [fragt_pkg::PCNT_W-1:0]      m_purged_count,
    input  logic                              cfg_wr_en,
    input  logic [fragt_pkg::AGE_W-1:0]       cfg_wr_data
);
    import fragt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [AGE_W-1:0] purge_age_reg;
    logic             m_valid_reg, m_valid_next;
    frag_result_t     out_reg, out_next;

    frag_desc_t       in_desc;
    frag_result_t     res;
    logic             res_valid;
    logic             res_ready;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    slot_entry_t      mem_rd_data;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    slot_entry_t      mem_wr_data;

    assign in_desc = '{is_ipv4: s_is_ipv4, ip_id: s_ip_id, frag_offset: s_frag_offset,
                       more_fragments: s_more_fragments, payload_length: s_payload_length,
                       now_ms: s_now_ms};

    assign res_ready = !m_valid_reg || m_ready;

    fragt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_desc      (in_desc),
        .purge_age_ms (purge_age_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data)
    );

    fragt_slot_mem #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_slot_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            purge_age_reg <= PURGE_AGE_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                purge_age_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_result_kind      = out_reg.result_kind;
    assign m_packet_id        = out_reg.packet_id;
    assign m_assembled_length = out_reg.assembled_length;
    assign m_purged_count     = out_reg.purged_count;

endmodule

/* src/fragt_slot_mem.sv */
// ----------------------------------------------------------------------------
// fragt_slot_mem
// Slot memory holding id, received count, total length and timestamp of each
// reassembly slot. One write port and one read port with registered data.
// ----------------------------------------------------------------------------
module fragt_slot_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_addr,
    input  fragt_pkg::slot_entry_t   wr_data,
    input  logic                     rd_en,
    input  logic [IDX_W-1:0]         rd_addr,
    output fragt_pkg::slot_entry_t   rd_data
);
    import fragt_pkg::*;

    slot_entry_t slot_mem_reg [DEPTH];
    slot_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= slot_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/fragt_ctrl.sv */
// ----------------------------------------------------------------------------
// fragt_ctrl
// Controller of the fragment tracker. Scans the slot memory once per IPv4
// transaction to find the matching or first free slot and the aged slots,
// then writes the updated slot back if the fragment is stored and presents one result.
// ----------------------------------------------------------------------------
module fragt_ctrl #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IDX_W         = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  fragt_pkg::frag_desc_t             in_desc,
    input  logic [fragt_pkg::AGE_W-1:0]       purge_age_ms,
    output logic                              res_valid,
    input  logic                              res_ready,
    output fragt_pkg::frag_result_t           res,
    output logic                              mem_rd_en,
    output logic [IDX_W-1:0]                  mem_rd_addr,
    input  fragt_pkg::slot_entry_t            mem_rd_data,
    output logic                              mem_wr_en,
    output logic [IDX_W-1:0]                  mem_wr_addr,
    output fragt_pkg::slot_entry_t            mem_wr_data
);
    import fragt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    ctrl_state_t state_reg, state_next;
    frag_desc_t  desc_reg, desc_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [TABLE_ENTRIES-1:0] slot_valid_reg, slot_valid_next;
    logic [TABLE_ENTRIES-1:0] cand_reg, cand_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             hit_cand_reg, hit_cand_next;
    logic [LEN_W-1:0] hit_rcv_reg, hit_rcv_next;
    logic [LEN_W-1:0] hit_tot_reg, hit_tot_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic              in_fire;
    logic              finish_fire;
    logic              entry_valid;
    logic [TIME_W-1:0] entry_age;
    logic              entry_old;
    logic              is_frag;
    logic              stored;
    logic [IDX_W-1:0]  slot_idx;
    logic [LEN_W-1:0]  base_rcv;
    logic [LEN_W-1:0]  base_tot;
    logic [LEN_W:0]    rcv_sum;
    logic [LEN_W-1:0]  new_rcv;
    logic [LEN_W-1:0]  new_tot;
    logic              complete;
    logic              hit_keep;
    logic [TABLE_ENTRIES-1:0] cand_eff;
    logic [CNT_W-1:0]  cnt_eff;
    logic [KIND_W-1:0] kind;

    assign in_fire     = in_valid && in_ready;
    assign finish_fire = (state_reg == ST_FINISH) && res_ready;

    assign entry_valid = slot_valid_reg[pend_idx_reg];
    assign entry_age   = desc_reg.now_ms - mem_rd_data.stamp;
    assign entry_old   = entry_age > TIME_W'(purge_age_ms);

    assign is_frag  = (desc_reg.frag_offset != '0) || desc_reg.more_fragments;
    assign stored   = is_frag && (hit_found_reg || free_found_reg);
    assign slot_idx = hit_found_reg ? hit_idx_reg : free_idx_reg;
    assign base_rcv = hit_found_reg ? hit_rcv_reg : '0;
    assign base_tot = hit_found_reg ? hit_tot_reg : '0;
    assign rcv_sum  = {1'b0, base_rcv} + (LEN_W + 1)'(desc_reg.payload_length);
    assign new_rcv  = rcv_sum[LEN_W] ? LEN_MAX : rcv_sum[LEN_W-1:0];
    assign new_tot  = desc_reg.more_fragments ? base_tot
                    : LEN_W'(desc_reg.frag_offset) + LEN_W'(desc_reg.payload_length);
    assign complete = (new_tot != '0) && (new_tot == new_rcv);
    assign hit_keep = stored && hit_found_reg;
    assign cand_eff = hit_keep ? (cand_reg & ~(TABLE_ENTRIES'(1) << hit_idx_reg)) : cand_reg;
    assign cnt_eff  = cnt_reg - CNT_W'(hit_keep && hit_cand_reg);

    always_comb begin
        if (!desc_reg.is_ipv4) begin
            kind = KIND_IGNORED;
        end else if (!is_frag) begin
            kind = KIND_PASS;
        end else if (!stored) begin
            kind = KIND_DROPPED;
        end else if (complete) begin
            kind = KIND_COMPLETE;
        end else begin
            kind = KIND_STORED;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = in_desc.is_ipv4 ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready    = (state_reg == ST_IDLE);
        mem_rd_en   = (state_reg == ST_SCAN);
        mem_rd_addr = scan_idx_reg;
        res_valid   = (state_reg == ST_FINISH);
        mem_wr_en   = finish_fire && stored;
        mem_wr_addr = slot_idx;
        mem_wr_data = '{id: desc_reg.ip_id, received: new_rcv, total: new_tot,
                        stamp: desc_reg.now_ms};
        res = '0;
        res.result_kind = kind;
        if (desc_reg.is_ipv4) begin
            res.packet_id        = desc_reg.ip_id;
            res.assembled_length = (kind == KIND_COMPLETE) ? new_rcv : '0;
            res.purged_count     = (32'(cnt_eff) > 32'(PCNT_MAX)) ? PCNT_MAX
                                                                   : PCNT_W'(cnt_eff);
        end
    end

    always_comb begin
        desc_next       = desc_reg;
        scan_idx_next   = scan_idx_reg;
        pend_valid_next = (state_reg == ST_SCAN);
        pend_idx_next   = scan_idx_reg;
        slot_valid_next = slot_valid_reg;
        cand_next       = cand_reg;
        cnt_next        = cnt_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_cand_next   = hit_cand_reg;
        hit_rcv_next    = hit_rcv_reg;
        hit_tot_next    = hit_tot_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;

        if (in_fire) begin
            desc_next       = in_desc;
            scan_idx_next   = '0;
            cand_next       = '0;
            cnt_next        = '0;
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
        end

        if (state_reg == ST_SCAN && scan_idx_reg != LAST_IDX) begin
            scan_idx_next = scan_idx_reg + IDX_W'(1);
        end

        if (pend_valid_reg) begin
            if (entry_valid) begin
                if (!hit_found_reg && mem_rd_data.id == desc_reg.ip_id) begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = pend_idx_reg;
                    hit_cand_next  = entry_old;
                    hit_rcv_next   = mem_rd_data.received;
                    hit_tot_next   = mem_rd_data.total;
                end
                if (entry_old) begin
                    cand_next[pend_idx_reg] = 1'b1;
                    cnt_next                = cnt_reg + CNT_W'(1);
                end
            end else if (!free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = pend_idx_reg;
            end
        end

        if (finish_fire && desc_reg.is_ipv4) begin
            slot_valid_next = slot_valid_reg & ~cand_eff;
            if (stored) begin
                slot_valid_next[slot_idx] = !complete;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            slot_valid_reg <= '0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg       <= desc_next;
        scan_idx_reg   <= scan_idx_next;
        pend_idx_reg   <= pend_idx_next;
        cand_reg       <= cand_next;
        cnt_reg        <= cnt_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_cand_reg   <= hit_cand_next;
        hit_rcv_reg    <= hit_rcv_next;
        hit_tot_reg    <= hit_tot_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
    end

`ifndef SYNTH
    a_write_only_at_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (state_reg == ST_FINISH) && res_ready)
        else $error("slot memory written outside the finish step");

    a_finish_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        finish_fire |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after a result");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_SCAN) || (state_reg == ST_FINISH))
        else $error("accepted transaction did not start processing");

    a_complete_has_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.result_kind == KIND_COMPLETE) |-> (res.assembled_length != '0))
        else $error("completed packet reported with zero length");

    a_no_read_during_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_rd_en && mem_wr_en))
        else $error("slot memory read and written in the same cycle");
`endif

endmodule

/* dv/fragt_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fragt_checker
// Watches both channels and the configuration port of the fragment tracker.
// It keeps its own copy of the slot table and of the purge age, and works out
// the result of each accepted descriptor. Each accepted result is compared,
// field by field, with the oldest outstanding prediction. Mismatches and
// unexpected results are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module fragt_checker #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_is_ipv4,
    input  logic [fragt_pkg::ID_W-1:0]    s_ip_id,
    input  logic [fragt_pkg::OFF_W-1:0]   s_frag_offset,
    input  logic                          s_more_fragments,
    input  logic [fragt_pkg::PLEN_W-1:0]  s_payload_length,
    input  logic [fragt_pkg::TIME_W-1:0]  s_now_ms,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [fragt_pkg::KIND_W-1:0]  m_result_kind,
    input  logic [fragt_pkg::ID_W-1:0]    m_packet_id,
    input  logic [fragt_pkg::LEN_W-1:0]   m_assembled_length,
    input  logic [fragt_pkg::PCNT_W-1:0]  m_purged_count,
    input  logic                          cfg_wr_en,
    input  logic [fragt_pkg::AGE_W-1:0]   cfg_wr_data,
    output int                            err_count,
    output int                            pending
);
    import fragt_pkg::*;

    logic          slot_used [TABLE_ENTRIES];
    slot_entry_t   slot_mem  [TABLE_ENTRIES];
    logic [AGE_W-1:0] age_limit;
    frag_result_t  result_q [$];

    function automatic frag_result_t track_fragment(frag_desc_t d);
        frag_result_t      r;
        int                hit;
        int                free_idx;
        int                purged;
        logic [LEN_W:0]    sum;
        logic [TIME_W-1:0] age;
        r = '0;
        if (!d.is_ipv4) begin
            return r;
        end
        r.packet_id = d.ip_id;
        if (d.frag_offset == '0 && !d.more_fragments) begin
            r.result_kind = KIND_PASS;
        end else begin
            hit      = -1;
            free_idx = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (slot_used[i]) begin
                    if (hit < 0 && slot_mem[i].id == d.ip_id) hit = i;
                end else if (free_idx < 0) begin
                    free_idx = i;
                end
            end
            if (hit < 0 && free_idx >= 0) begin
                hit              = free_idx;
                slot_used[hit]   = 1'b1;
                slot_mem[hit]    = '0;
                slot_mem[hit].id = d.ip_id;
            end
            if (hit < 0) begin
                r.result_kind = KIND_DROPPED;
            end else begin
                sum = {1'b0, slot_mem[hit].received} + {1'b0, LEN_W'(d.payload_length)};
                slot_mem[hit].received = (sum > LEN_MAX) ? LEN_MAX : sum[LEN_W-1:0];
                slot_mem[hit].stamp    = d.now_ms;
                if (!d.more_fragments) begin
                    slot_mem[hit].total = LEN_W'(d.frag_offset) + LEN_W'(d.payload_length);
                end
                if (slot_mem[hit].total != '0 &&
                    slot_mem[hit].total == slot_mem[hit].received) begin
                    r.result_kind      = KIND_COMPLETE;
                    r.assembled_length = slot_mem[hit].received;
                    slot_used[hit]     = 1'b0;
                end else begin
                    r.result_kind = KIND_STORED;
                end
            end
        end
        purged = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_used[i]) begin
                age = d.now_ms - slot_mem[i].stamp;
                if (age > TIME_W'(age_limit)) begin
                    slot_used[i] = 1'b0;
                    if (purged < int'(PCNT_MAX)) purged++;
                end
            end
        end
        r.purged_count = PCNT_W'(purged);
        return r;
    endfunction

    always @(posedge aclk) begin
        frag_desc_t   desc;
        frag_result_t seen;
        frag_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                slot_used[i] = 1'b0;
                slot_mem[i]  = '0;
            end
            age_limit = PURGE_AGE_RESET;
            result_q.delete();
        end else begin
            if (cfg_wr_en) begin
                age_limit = cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                seen.result_kind      = m_result_kind;
                seen.packet_id        = m_packet_id;
                seen.assembled_length = m_assembled_length;
                seen.purged_count     = m_purged_count;
                if (result_q.size() == 0) begin
                    if (err_count < 10) begin
                        $display("%0t: unexpected result transaction: kind %0d id %h len %0d purged %0d",
                                 $realtime, seen.result_kind, seen.packet_id,
                                 seen.assembled_length, seen.purged_count);
                    end
                    err_count++;
                end else begin
                    want = result_q.pop_front();
                    if (seen.result_kind !== want.result_kind ||
                        seen.packet_id !== want.packet_id ||
                        seen.assembled_length !== want.assembled_length ||
                        seen.purged_count !== want.purged_count) begin
                        if (err_count < 10) begin
                            $display("%0t: mismatch: expected kind %0d id %h len %0d purged %0d",
                                     $realtime, want.result_kind, want.packet_id,
                                     want.assembled_length, want.purged_count);
                            $display("%0t:           got kind %0d id %h len %0d purged %0d",
                                     $realtime, seen.result_kind, seen.packet_id,
                                     seen.assembled_length, seen.purged_count);
                        end
                        err_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                desc.is_ipv4        = s_is_ipv4;
                desc.ip_id          = s_ip_id;
                desc.frag_offset    = s_frag_offset;
                desc.more_fragments = s_more_fragments;
                desc.payload_length = s_payload_length;
                desc.now_ms         = s_now_ms;
                result_q.insert(result_q.size(), track_fragment(desc));
            end
        end
        pending = result_q.size();
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the IPv4 fragment tracker. A short directed sequence covers
// ignored frames, pass-through packets, completion, repeated last fragments,
// saturation, a full table and a full purge. Random phases follow, each but
// the first after a purge age write, mixing interleaved well-formed fragment trains with
// noise. Both channels idle at random; the receiver stalls once for a long
// stretch. The checker module does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
    import fragt_pkg::*;

    localparam int TABLE_ENTRIES  = 16;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_AT_RESULT = 350;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 30;
    localparam logic [TIME_W-1:0] T0 = 32'hFFFF_FF00;

    logic               aclk             = 1'b0;
    logic               aresetn          = 1'b0;
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic               s_is_ipv4        = 1'b0;
    logic [ID_W-1:0]    s_ip_id          = '0;
    logic [OFF_W-1:0]   s_frag_offset    = '0;
    logic               s_more_fragments = 1'b0;
    logic [PLEN_W-1:0]  s_payload_length = '0;
    logic [TIME_W-1:0]  s_now_ms         = '0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic [KIND_W-1:0]  m_result_kind;
    logic [ID_W-1:0]    m_packet_id;
    logic [LEN_W-1:0]   m_assembled_length;
    logic [PCNT_W-1:0]  m_purged_count;
    logic               cfg_wr_en        = 1'b0;
    logic [AGE_W-1:0]   cfg_wr_data      = '0;
    int                 checker_errors;
    int                 checker_pending;

    typedef struct packed {
        logic [ID_W-1:0]              id;
        logic [2:0]                   nfrag;
        logic [2:0]                   sent;
        logic [3:0][OFF_W-1:0]        off;
        logic [3:0][PLEN_W-1:0]       len;
        logic [3:0]                   mf;
    } pkt_plan_t;

    pkt_plan_t         open_pkts [$];
    logic [TIME_W-1:0] tnow;
    int                send_burst  = 0;
    int                recv_burst  = 0;
    int                pool_target = 8;
    int                recv_count  = 0;
    int                cycle_count = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    ipv4_fragment_tracker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_is_ipv4          (s_is_ipv4),
        .s_ip_id            (s_ip_id),
        .s_frag_offset      (s_frag_offset),
        .s_more_fragments   (s_more_fragments),
        .s_payload_length   (s_payload_length),
        .s_now_ms           (s_now_ms),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_kind      (m_result_kind),
        .m_packet_id        (m_packet_id),
        .m_assembled_length (m_assembled_length),
        .m_purged_count     (m_purged_count),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data)
    );

    fragt_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) i_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_is_ipv4          (s_is_ipv4),
        .s_ip_id            (s_ip_id),
        .s_frag_offset      (s_frag_offset),
        .s_more_fragments   (s_more_fragments),
        .s_payload_length   (s_payload_length),
        .s_now_ms           (s_now_ms),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_kind      (m_result_kind),
        .m_packet_id        (m_packet_id),
        .m_assembled_length (m_assembled_length),
        .m_purged_count     (m_purged_count),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .err_count          (checker_errors),
        .pending            (checker_pending)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // A run of zero-gap transactions now and then keeps back-to-back traffic
    // in the mix.
    function automatic int draw_gap(inout int burst_left);
        int gap;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(8, 40);
        end else begin
            gap = $urandom_range(0, 12);
        end
        return gap;
    endfunction

    function automatic pkt_plan_t plan_packet();
        pkt_plan_t         p;
        int                n;
        int                pos;
        int                j;
        logic [OFF_W-1:0]  t_off;
        logic [PLEN_W-1:0] t_len;
        logic              t_mf;
        p       = '0;
        p.id    = ID_W'($urandom);
        n       = $urandom_range(2, 4);
        p.nfrag = 3'(n);
        pos     = 0;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0: p.len[k] = '0;
                1: p.len[k] = PLEN_W'($urandom_range(1481, 8000));
                default: p.len[k] = PLEN_W'($urandom_range(1, 1480));
            endcase
            p.off[k] = OFF_W'(pos);
            p.mf[k]  = (k != n - 1);
            pos += p.len[k];
        end
        for (int k = n - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            t_off    = p.off[k];
            t_len    = p.len[k];
            t_mf     = p.mf[k];
            p.off[k] = p.off[j];
            p.len[k] = p.len[j];
            p.mf[k]  = p.mf[j];
            p.off[j] = t_off;
            p.len[j] = t_len;
            p.mf[j]  = t_mf;
        end
        return p;
    endfunction

    task automatic send_frag(input logic is4, input logic [ID_W-1:0] id,
                             input logic [OFF_W-1:0] off, input logic mf,
                             input logic [PLEN_W-1:0] len, input logic [TIME_W-1:0] now);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_is_ipv4        <= is4;
        s_ip_id          <= id;
        s_frag_offset    <= off;
        s_more_fragments <= mf;
        s_payload_length <= len;
        s_now_ms         <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic run_random(input int count);
        int        done;
        int        sel;
        int        idx;
        pkt_plan_t p;
        done = 0;
        while (done < count) begin
            if (done % 50 == 0) pool_target = $urandom_range(2, 22);
            tnow += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if ($urandom_range(0, 49) == 0) tnow += $urandom_range(1000, 70000);
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
                send_frag(1'b0, ID_W'($urandom), OFF_W'($urandom), 1'($urandom),
                          PLEN_W'($urandom), $urandom);
            end else begin
                done++;
                if (sel < 12) begin
                    send_frag(1'b1, ID_W'($urandom), '0, 1'b0, PLEN_W'($urandom), tnow);
                end else if (sel < 20) begin
                    send_frag(1'b1, ID_W'($urandom), OFF_W'($urandom), 1'($urandom),
                              PLEN_W'($urandom),
                              ($urandom_range(0, 2) == 0) ? $urandom : tnow);
                end else begin
                    if (open_pkts.size() == 0 ||
                        (open_pkts.size() < pool_target && $urandom_range(0, 2) == 0)) begin
                        open_pkts.insert(open_pkts.size(), plan_packet());
                    end
                    idx = $urandom_range(0, open_pkts.size() - 1);
                    p   = open_pkts[idx];
                    send_frag(1'b1, p.id, p.off[p.sent[1:0]], p.mf[p.sent[1:0]],
                              p.len[p.sent[1:0]], tnow);
                    p.sent++;
                    if (p.sent == p.nfrag) begin
                        open_pkts.delete(idx);
                    end else begin
                        open_pkts[idx] = p;
                    end
                end
            end
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (checker_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_age(input logic [AGE_W-1:0] age);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= age;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (recv_count == HOLD_AT_RESULT) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = draw_gap(recv_burst);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            recv_count++;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_frag(1'b0, '1, '1, 1'b1, '1, '1);
        send_frag(1'b1, '1, '0, 1'b0, '1, T0);
        send_frag(1'b1, 16'hA001, 16'd0, 1'b1, 16'd1000, T0 + 1);
        send_frag(1'b1, 16'hA001, 16'd1000, 1'b0, 16'd500, T0 + 2);
        // A second last fragment replaces the total of the first one.
        send_frag(1'b1, 16'hA002, 16'd100, 1'b0, 16'd100, T0 + 3);
        send_frag(1'b1, 16'hA002, 16'd50, 1'b0, 16'd50, T0 + 4);
        // Three maximum fragments saturate the received count.
        for (int k = 0; k < 3; k++) begin
            send_frag(1'b1, 16'hA004, 16'd8, 1'b1, '1, T0 + 5 + k);
        end
        send_frag(1'b1, 16'hA004, '1, 1'b0, '1, T0 + 8);
        // Empty fragments with unknown totals fill the rest of the table.
        for (int k = 0; k < TABLE_ENTRIES - 2; k++) begin
            send_frag(1'b1, ID_W'(k), '0, 1'b1, '0, T0 + 10 + k);
        end
        send_frag(1'b1, 16'hB000, 16'h1234, 1'b1, 16'd100, T0 + 30);
        // The clock wraps here and every slot is past the default age.
        send_frag(1'b1, 16'h4242, '0, 1'b0, 16'd1, T0 + 6000);

        tnow = T0 + 6000;
        run_random(150);

        settle();
        write_age('0);
        tnow = $urandom;
        run_random(140);

        settle();
        write_age('1);
        tnow = $urandom;
        run_random(140);

        settle();
        write_age(AGE_W'($urandom_range(50, 3000)));
        run_random(140);

        settle();
        write_age(PURGE_AGE_RESET);
        run_random(140);

        settle();
        if (checker_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
